// File: rtl/core/fire_heat_line_simulator_macros.svh
// Assertion macros shared by the flame-line heat simulator checkers.
// No dependencies; included by the checker file.
`ifndef FIRE_HEAT_LINE_SIMULATOR_MACROS_SVH
`define FIRE_HEAT_LINE_SIMULATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FHL_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fhl check failed");

// Next-cycle implication, disabled during reset
`define FHL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fhl check failed");

`endif

// File: rtl/core/fhl_pkg.sv
// Shared types, constants and helpers for the flame-line heat simulator.
// No dependencies; every file but the assertion macros header imports it.
`default_nettype none

package fhl_pkg;

    // Default sizes
    localparam int MAX_CELLS_DEF = 64;
    localparam int MAX_LINES_DEF = 16;

    // Field widths
    localparam int HEAT_W      = 8;
    localparam int LINE_W      = 4;
    localparam int CELL_W      = 6;
    localparam int POS_W       = 6;
    localparam int RAND_W      = 8;
    localparam int NCELL_W     = 7;
    localparam int NLINE_W     = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int SPARK_POS_W = 3;
    localparam int DIVIDEND_W  = 12;
    localparam int MEM_AW_DEF  = CELL_W + LINE_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COOLING   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARKING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CELLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LINES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT    = 3'd4;

    // Register reset values
    localparam logic [HEAT_W-1:0]  COOLING_RST   = 8'd55;
    localparam logic [HEAT_W-1:0]  SPARKING_RST  = 8'd120;
    localparam logic [NCELL_W-1:0] NUM_CELLS_RST = 7'd64;
    localparam logic [NLINE_W-1:0] NUM_LINES_RST = 5'd16;
    localparam logic               DIRECT_RST    = 1'b1;

    // Opcodes
    localparam logic OP_COOL   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Model constants
    localparam int COOL_MULT         = 10;
    localparam int COOL_BIAS         = 2;
    localparam int ROLL_SPAN         = 255;
    localparam int SPARK_HEAT_BASE   = 160;
    localparam int SPARK_HEAT_SPAN   = 95;
    localparam int SPARK_SPAN_WIDE   = 7;
    localparam int SPARK_SPAN_NARROW = 2;
    localparam int HEAT_MAX          = 255;
    localparam int MIN_CELLS         = 2;
    localparam int FIRST_DIFF_CELL   = 2;
    localparam int DIV3              = 3;
    // x/3 == (x*683)>>11 for every x up to 765
    localparam int DIV3_SHIFT        = 11;
    localparam int DIV3_RECIP        = (1 << DIV3_SHIFT) / DIV3 + 1;

    // Per-beat context captured at accept
    typedef struct packed {
        logic                   finish;
        logic                   fire;
        logic [SPARK_POS_W-1:0] spark_pos;
        logic [HEAT_W-1:0]      spark_heat;
        logic [HEAT_W-1:0]      amt;
        logic                   direct;
    } item_t;

    // Pipeline status back to the controller
    typedef struct packed {
        logic adv;
        logic busy;
    } pipe_stat_t;

    // r * n >> 8
    function automatic logic [HEAT_W-1:0] scale8(input logic [RAND_W-1:0] r,
                                                 input logic [HEAT_W-1:0] n);
        logic [2*HEAT_W-1:0] p;
        p = (2*HEAT_W)'(r) * (2*HEAT_W)'(n);
        return p[2*HEAT_W-1:HEAT_W];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fire_heat_line_simulator.sv
// Channel  Handshake             Beat fields
// cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in_valid/in_ready     op, line, cell_req, cool_rand, spark_roll,
//                                spark_pos_rand, spark_heat_rand
// out      out_valid/out_ready   position, heat_value, last
//
// Cool beat: one cell through the read-modify-write pipe, drained before the next accept.
// Finish beat: one cell per cycle through the single heat memory read port, held
// while out_ready is low and the result register is full.
// Beats on unused lines or cells beyond the line are taken and dropped.
// After reset a clearing pass zeroes all MAX_LINES (at least 2) times
// 2**ceil(log2(MAX_CELLS)) heat memory words, 1024 by default, with in_ready low.
// After any config write the cool limit divider reruns, with in_ready low.
//
// Top level of the flame-line heat simulator: control, config, clearing.
// Depends on fhl_pkg, fhl_heat_mem, fhl_div, fhl_cell_pipe.
`default_nettype none

module fire_heat_line_simulator #(
    parameter int MAX_CELLS = fhl_pkg::MAX_CELLS_DEF,
    parameter int MAX_LINES = fhl_pkg::MAX_LINES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fhl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fhl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           op,
    input  wire logic [fhl_pkg::LINE_W-1:0]     line,
    input  wire logic [fhl_pkg::CELL_W-1:0]     cell_req,
    input  wire logic [fhl_pkg::RAND_W-1:0]     cool_rand,
    input  wire logic [fhl_pkg::RAND_W-1:0]     spark_roll,
    input  wire logic [fhl_pkg::RAND_W-1:0]     spark_pos_rand,
    input  wire logic [fhl_pkg::RAND_W-1:0]     spark_heat_rand,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [fhl_pkg::POS_W-1:0]      position,
    output logic      [fhl_pkg::HEAT_W-1:0]     heat_value,
    output logic                                last
);
    import fhl_pkg::*;

    localparam int CW        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int LW        = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LINE_ROWS = (MAX_LINES > 1) ? MAX_LINES : 2;
    localparam int DEPTH     = LINE_ROWS << CW;
    localparam int AW        = LW + CW;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               dirty_reg;
    logic [CW-1:0]      issue_cell_reg;
    logic [CW-1:0]      issue_last_reg;
    logic [CW-1:0]      cell_last_reg;
    logic [LW-1:0]      line_idx_reg;
    item_t              item_reg;
    item_t              item_next;

    logic [HEAT_W-1:0]  cooling_reg;
    logic [HEAT_W-1:0]  sparking_reg;
    logic [NCELL_W-1:0] num_cells_reg;
    logic [NLINE_W-1:0] num_lines_reg;
    logic               direct_reg;

    logic               cfg_fire;
    logic               in_fire;
    logic [NCELL_W-1:0] n_eff;
    logic               line_in_use;
    logic               skip;
    logic [HEAT_W-1:0]  span;
    logic               div_busy;
    logic [DIVIDEND_W-1:0] quot;
    logic [HEAT_W-1:0]  lim;
    logic               lim_ok;
    logic               issue;
    pipe_stat_t         stat;
    logic               wr_en;
    logic [CW-1:0]      wr_cell;
    logic [HEAT_W-1:0]  wr_data;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [HEAT_W-1:0]  mem_wdata;
    logic [HEAT_W-1:0]  mem_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooling_reg   <= COOLING_RST;
            sparking_reg  <= SPARKING_RST;
            num_cells_reg <= NUM_CELLS_RST;
            num_lines_reg <= NUM_LINES_RST;
            direct_reg    <= DIRECT_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_COOLING:   cooling_reg   <= cfg_data;
                REG_SPARKING:  sparking_reg  <= cfg_data;
                REG_NUM_CELLS: num_cells_reg <= cfg_data[NCELL_W-1:0];
                REG_NUM_LINES: num_lines_reg <= cfg_data[NLINE_W-1:0];
                REG_DIRECT:    direct_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Effective cell count and line check
    always_comb
    begin
        priority if (num_cells_reg < NCELL_W'(MIN_CELLS))
        begin
            n_eff = NCELL_W'(MIN_CELLS);
        end
        else if (int'(num_cells_reg) > MAX_CELLS)
        begin
            n_eff = NCELL_W'(MAX_CELLS);
        end
        else
        begin
            n_eff = num_cells_reg;
        end

        if (num_lines_reg == '0)
        begin
            line_in_use = (line == '0);
        end
        else
        begin
            line_in_use = (NLINE_W'(line) < num_lines_reg);
        end
        line_in_use = line_in_use && (int'(line) < MAX_LINES);

        skip = !line_in_use || (op == OP_COOL && NCELL_W'(cell_req) >= n_eff);
    end

    // Cool limit: (cooling*10/n + 2) mod 256, recomputed after config writes
    fhl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dirty_reg),
        .dividend (DIVIDEND_W'(cooling_reg) * DIVIDEND_W'(COOL_MULT)),
        .divisor  (n_eff),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign lim    = HEAT_W'(quot + DIVIDEND_W'(COOL_BIAS));
    assign lim_ok = !dirty_reg && !div_busy;

    // Scaled randoms captured with the beat
    always_comb
    begin
        span = (n_eff < NCELL_W'(SPARK_SPAN_WIDE)) ? HEAT_W'(SPARK_SPAN_NARROW)
                                                   : HEAT_W'(SPARK_SPAN_WIDE);
        item_next.finish     = (op == OP_FINISH);
        item_next.fire       = scale8(spark_roll, HEAT_W'(ROLL_SPAN)) < sparking_reg;
        item_next.spark_pos  = SPARK_POS_W'(scale8(spark_pos_rand, span));
        item_next.spark_heat = HEAT_W'(SPARK_HEAT_BASE)
                               + scale8(spark_heat_rand, HEAT_W'(SPARK_HEAT_SPAN));
        item_next.amt        = scale8(cool_rand, lim);
        item_next.direct     = direct_reg;
    end

    assign in_ready = (state_reg == ST_IDLE) && lim_ok;
    assign issue    = (state_reg == ST_RUN) && stat.adv;

    // Controller: clearing pass, then one beat at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            dirty_reg      <= 1'b1;
            issue_cell_reg <= '0;
        end
        else
        begin
            dirty_reg <= cfg_fire;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire && !skip)
                    begin
                        state_reg      <= ST_RUN;
                        issue_cell_reg <= (op == OP_COOL) ? CW'(cell_req) : '0;
                    end
                end
                ST_RUN:
                begin
                    if (stat.adv)
                    begin
                        if (issue_cell_reg == issue_last_reg)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            issue_cell_reg <= issue_cell_reg + CW'(1);
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (!stat.busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Beat context held for the whole walk
    always_ff @(posedge clk)
    begin
        if (in_fire && !skip)
        begin
            item_reg       <= item_next;
            line_idx_reg   <= LW'(line);
            issue_last_reg <= (op == OP_COOL) ? CW'(cell_req)
                                              : CW'(n_eff - NCELL_W'(1));
            cell_last_reg  <= CW'(n_eff - NCELL_W'(1));
        end
    end

    // Write port shared between the clearing pass and the pipe
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = {line_idx_reg, wr_cell};
            mem_wdata = wr_data;
        end
    end

    fhl_heat_mem #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_heat_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr ({line_idx_reg, issue_cell_reg}),
        .rdata (mem_rdata)
    );

    fhl_cell_pipe #(
        .CW (CW)
    ) u_cell_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .issue_cell (issue_cell_reg),
        .item       (item_reg),
        .cell_last  (cell_last_reg),
        .rdata      (mem_rdata),
        .wr_en      (wr_en),
        .wr_cell    (wr_cell),
        .wr_data    (wr_data),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .heat_value (heat_value),
        .last       (last)
    );

endmodule

`default_nettype wire

// File: rtl/core/fhl_heat_mem.sv
// Heat store: simple dual-port synchronous RAM, registered read data.
// Depends on fhl_pkg.
`default_nettype none

module fhl_heat_mem #(
    parameter int AW    = fhl_pkg::MEM_AW_DEF,
    parameter int DEPTH = 1 << fhl_pkg::MEM_AW_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [fhl_pkg::HEAT_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [fhl_pkg::HEAT_W-1:0] rdata
);
    import fhl_pkg::*;

    logic [HEAT_W-1:0] mem [DEPTH];
    logic [HEAT_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/fhl_div.sv
// Shift-subtract divider, one quotient bit per cycle, for the cool limit.
// Depends on fhl_pkg.
`default_nettype none

module fhl_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [fhl_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [fhl_pkg::NCELL_W-1:0]    divisor,
    output logic                               busy,
    output logic      [fhl_pkg::DIVIDEND_W-1:0] quotient
);
    import fhl_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [NCELL_W-1:0]    dsr_reg;
    logic [NCELL_W-1:0]    rem_reg;
    logic [NCELL_W:0]      trial;
    logic [NCELL_W:0]      diff;
    logic                  fits;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // Control: a start restarts at any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Datapath: dividend shifts out, quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[NCELL_W-1:0] : trial[NCELL_W-1:0];
            dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// File: rtl/core/fhl_cell_pipe.sv
// Read-modify-write cell pipeline: diffusion, spark, cooling, result register.
// Depends on fhl_pkg; fed by the heat memory read port.
`default_nettype none

module fhl_cell_pipe #(
    parameter int CW = fhl_pkg::CELL_W
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       issue,
    input  wire logic [CW-1:0]              issue_cell,
    input  wire fhl_pkg::item_t             item,
    input  wire logic [CW-1:0]              cell_last,
    input  wire logic [fhl_pkg::HEAT_W-1:0] rdata,
    output logic                            wr_en,
    output logic      [CW-1:0]              wr_cell,
    output logic      [fhl_pkg::HEAT_W-1:0] wr_data,
    output fhl_pkg::pipe_stat_t             stat,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [fhl_pkg::POS_W-1:0]  position,
    output logic      [fhl_pkg::HEAT_W-1:0] heat_value,
    output logic                            last
);
    import fhl_pkg::*;

    localparam int SUM_W  = HEAT_W + 2;
    localparam int PROD_W = 2 * SUM_W;

    logic              adv;
    logic              a_valid_reg, b_valid_reg, c_valid_reg, out_valid_reg;
    logic [CW-1:0]     a_cell_reg, b_cell_reg, c_cell_reg;
    logic [HEAT_W-1:0] w1_reg, w2_reg;
    logic [SUM_W-1:0]  b_sum_reg;
    logic [HEAT_W-1:0] b_old_reg;
    logic [HEAT_W-1:0] c_heat_reg;
    logic [POS_W-1:0]  position_reg;
    logic [HEAT_W-1:0] heat_reg;
    logic              last_reg;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [HEAT_W-1:0] diffused;
    logic [HEAT_W:0]   spark_sum;
    logic [HEAT_W-1:0] new_heat;
    logic [CW-1:0]     out_pos;

    // Whole pipe moves unless the result register is stuck
    assign adv = !out_valid_reg || out_ready;

    // Stage A: old[j-1] + 2*old[j-2] from the two-entry window
    assign sum = SUM_W'(w1_reg) + SUM_W'({w2_reg, 1'b0});

    // Stage B: divide by 3 through the reciprocal; lowest two cells pass
    always_comb
    begin
        prod     = PROD_W'(b_sum_reg) * PROD_W'(DIV3_RECIP);
        diffused = (item.finish && int'(b_cell_reg) >= FIRST_DIFF_CELL)
                   ? prod[DIV3_SHIFT +: HEAT_W] : b_old_reg;
    end

    // Stage C: spark or cooling, then write back
    always_comb
    begin
        spark_sum = (HEAT_W+1)'(c_heat_reg) + (HEAT_W+1)'(item.spark_heat);
        priority if (!item.finish)
        begin
            new_heat = (c_heat_reg > item.amt) ? (c_heat_reg - item.amt) : '0;
        end
        else if (item.fire && int'(c_cell_reg) == int'(item.spark_pos))
        begin
            new_heat = spark_sum[HEAT_W] ? HEAT_W'(HEAT_MAX) : spark_sum[HEAT_W-1:0];
        end
        else
        begin
            new_heat = c_heat_reg;
        end
        out_pos = item.direct ? c_cell_reg : (cell_last - c_cell_reg);
    end

    // Stage valid flags and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= issue;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg && item.finish;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cell_reg   <= issue_cell;
            b_cell_reg   <= a_cell_reg;
            b_sum_reg    <= sum;
            b_old_reg    <= rdata;
            c_cell_reg   <= b_cell_reg;
            c_heat_reg   <= diffused;
            position_reg <= POS_W'(out_pos);
            heat_reg     <= new_heat;
            last_reg     <= (c_cell_reg == cell_last);
            if (a_valid_reg)
            begin
                w1_reg <= rdata;
                w2_reg <= w1_reg;
            end
        end
    end

    assign wr_en      = c_valid_reg && adv;
    assign wr_cell    = c_cell_reg;
    assign wr_data    = new_heat;
    assign stat.adv   = adv;
    assign stat.busy  = a_valid_reg || b_valid_reg || c_valid_reg;
    assign out_valid  = out_valid_reg;
    assign position   = position_reg;
    assign heat_value = heat_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/fhl_checker.sv
// Port-level checks for the flame-line heat simulator, bound to the top.
// Depends on fhl_pkg and fire_heat_line_simulator_macros.svh.
`default_nettype none
`include "fire_heat_line_simulator_macros.svh"

module fhl_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [fhl_pkg::POS_W-1:0]  position,
    input wire logic [fhl_pkg::HEAT_W-1:0] heat_value,
    input wire logic                       last
);
    import fhl_pkg::*;

    logic in_seen;
    assign in_seen = in_valid;

    // A stalled result beat holds
    `FHL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(position) && $stable(heat_value) && $stable(last))

    // No new beat is taken while a line is still being emitted
    `FHL_ASSERT_NOW(a_no_accept_mid_line, clk, rst_n, (in_seen || !in_seen) && out_valid && !last, !in_ready)

    // A line streams without gaps once its results flow
    `FHL_ASSERT_NEXT(a_line_streams, clk, rst_n, out_valid && out_ready && !last, out_valid)

endmodule

bind fire_heat_line_simulator fhl_checker u_fhl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .position   (position),
    .heat_value (heat_value),
    .last       (last)
);

`default_nettype wire

// File: verif/tb.sv
// Self-checking bench for fire_heat_line_simulator: directed and random beats,
// a scoreboard class that tracks every line's heat, idling on both channels.
// Depends on fhl_pkg and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fhl_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 100;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 600;
    localparam int MAX_PRINTS    = 30;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [HEAT_W-1:0] heat_value;
        logic              last;
    } cell_beat_t;

    // Heat tracker: own copy of the registers and of every line's cells
    class flame_scoreboard;
        logic [HEAT_W-1:0]  heat [MAX_LINES_DEF][MAX_CELLS_DEF];
        logic [HEAT_W-1:0]  cooling;
        logic [HEAT_W-1:0]  sparking;
        logic [NCELL_W-1:0] num_cells;
        logic [NLINE_W-1:0] num_lines;
        logic               direct;
        cell_beat_t         pending [$];
        int errors, beats_checked, cools, line_updates, ignored, sparks;

        function new();
            foreach (heat[l, c]) heat[l][c] = '0;
            cooling   = COOLING_RST;
            sparking  = SPARKING_RST;
            num_cells = NUM_CELLS_RST;
            num_lines = NUM_LINES_RST;
            direct    = DIRECT_RST;
            errors = 0; beats_checked = 0; cools = 0;
            line_updates = 0; ignored = 0; sparks = 0;
        endfunction

        // random byte stretched over 0..span-1
        function int scale_byte(int r, int span);
            return (r * span) >> 8;
        endfunction

        function int cells_in_use();
            int n;
            n = num_cells;
            if (n < MIN_CELLS) n = MIN_CELLS;
            if (n > MAX_CELLS_DEF) n = MAX_CELLS_DEF;
            return n;
        endfunction

        function int lines_in_use();
            int n;
            n = num_lines;
            if (n < 1) n = 1;
            if (n > MAX_LINES_DEF) n = MAX_LINES_DEF;
            return n;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_COOLING:   cooling   = data;
                REG_SPARKING:  sparking  = data;
                REG_NUM_CELLS: num_cells = data[NCELL_W-1:0];
                REG_NUM_LINES: num_lines = data[NLINE_W-1:0];
                REG_DIRECT:    direct    = data[0];
                default: ;
            endcase
        endfunction

        // unused lines and cells past the end of the line are dropped
        function bit takes_effect(logic o, int ln, int c);
            if (ln >= lines_in_use()) return 1'b0;
            return (o == OP_FINISH) || (c < cells_in_use());
        endfunction

        function void note_input(logic o, logic [LINE_W-1:0] ln, logic [CELL_W-1:0] c,
                                 logic [RAND_W-1:0] cr, logic [RAND_W-1:0] sr,
                                 logic [RAND_W-1:0] pr, logic [RAND_W-1:0] hr);
            int n, lim, amt, cur, pos, sum;
            cell_beat_t beat;
            n = cells_in_use();
            if (!takes_effect(o, ln, c)) begin
                ignored++;
                return;
            end
            // cool: bounded random loss, floor at zero
            if (o == OP_COOL) begin
                lim = (int'(cooling) * COOL_MULT / n + COOL_BIAS) & 'hFF;
                amt = scale_byte(cr, lim);
                cur = heat[ln][c];
                heat[ln][c] = HEAT_W'((cur > amt) ? cur - amt : 0);
                cools++;
                return;
            end
            // diffuse upward, top cell first
            for (int j = n - 1; j >= FIRST_DIFF_CELL; j--)
                heat[ln][j] = HEAT_W'((int'(heat[ln][j-1]) + 2 * int'(heat[ln][j-2])) / DIV3);
            // spark near the bottom, saturating
            if (scale_byte(sr, ROLL_SPAN) < int'(sparking)) begin
                pos = scale_byte(pr, (n < SPARK_SPAN_WIDE) ? SPARK_SPAN_NARROW : SPARK_SPAN_WIDE);
                sum = int'(heat[ln][pos]) + SPARK_HEAT_BASE + scale_byte(hr, SPARK_HEAT_SPAN);
                heat[ln][pos] = HEAT_W'((sum > HEAT_MAX) ? HEAT_MAX : sum);
                sparks++;
            end
            // one beat per cell; position flips when direct is off
            for (int j = 0; j < n; j++) begin
                beat.position   = POS_W'(direct ? j : n - 1 - j);
                beat.heat_value = heat[ln][j];
                beat.last       = (j == n - 1);
                pending.push_back(beat);
            end
            line_updates++;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("[%0t] ERROR %s", $time, msg);
        endtask

        task check_result(logic [POS_W-1:0] p, logic [HEAT_W-1:0] h, logic l);
            cell_beat_t want;
            beats_checked++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat: position %0d heat %0d last %0d", p, h, l));
                return;
            end
            want = pending.pop_front();
            if (p !== want.position)
                report($sformatf("position %0d, want %0d", p, want.position));
            if (h !== want.heat_value)
                report($sformatf("heat_value %0d, want %0d (position %0d)", h, want.heat_value,
                                 want.position));
            if (l !== want.last)
                report($sformatf("last %0d, want %0d (position %0d)", l, want.last,
                                 want.position));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  op        = OP_COOL;
    logic [LINE_W-1:0]     line      = '0;
    logic [CELL_W-1:0]     cell_req  = '0;
    logic [RAND_W-1:0]     cool_rand       = '0;
    logic [RAND_W-1:0]     spark_roll      = '0;
    logic [RAND_W-1:0]     spark_pos_rand  = '0;
    logic [RAND_W-1:0]     spark_heat_rand = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [POS_W-1:0]      position;
    logic [HEAT_W-1:0]     heat_value;
    logic                  last;

    flame_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int settings_used = 0;
    int cycle_count   = 0;

    fire_heat_line_simulator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .line            (line),
        .cell_req        (cell_req),
        .cool_rand       (cool_rand),
        .spark_roll      (spark_roll),
        .spark_pos_rand  (spark_pos_rand),
        .spark_heat_rand (spark_heat_rand),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .position        (position),
        .heat_value      (heat_value),
        .last            (last)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fire_heat_line_simulator: mismatch");
            $finish;
        end
    end

    // Output side: random back-pressure, plus long hold-offs on request
    initial
    begin : receiver
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_asks) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Beat monitor: results first, then the input that was taken this edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(position, heat_value, last);
            if (in_valid && in_ready)
                sb.note_input(op, line, cell_req, cool_rand, spark_roll, spark_pos_rand,
                              spark_heat_rand);
        end
    end

    function automatic logic [RAND_W-1:0] any_byte();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return RAND_W'($urandom_range(255));
        endcase
    endfunction

    task automatic set_idle(int snd, int rcv);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
    endtask

    // Drain everything in flight before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, CFG_DATA_W'(data));
    endtask

    task automatic apply_setting(int cool_v, int spark_v, int cells_v, int lines_v, int dir_v);
        settle();
        write_reg(REG_COOLING, cool_v);
        write_reg(REG_SPARKING, spark_v);
        write_reg(REG_NUM_CELLS, cells_v);
        write_reg(REG_NUM_LINES, lines_v);
        write_reg(REG_DIRECT, dir_v);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_item(logic o, int ln, int c, int cr, int sr, int pr, int hr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        op              <= o;
        line            <= LINE_W'(ln);
        cell_req        <= CELL_W'(c);
        cool_rand       <= RAND_W'(cr);
        spark_roll      <= RAND_W'(sr);
        spark_pos_rand  <= RAND_W'(pr);
        spark_heat_rand <= RAND_W'(hr);
        in_valid        <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // Mostly live lines and cells, some stray ones
    task automatic send_random_item(output bit acted);
        logic o;
        int   ln, c;
        o  = ($urandom_range(99) < 55) ? OP_COOL : OP_FINISH;
        ln = ($urandom_range(9) == 0) ? $urandom_range((1 << LINE_W) - 1)
                                      : $urandom_range(sb.lines_in_use() - 1);
        c  = ($urandom_range(9) == 0) ? $urandom_range((1 << CELL_W) - 1)
                                      : $urandom_range(sb.cells_in_use() - 1);
        acted = sb.takes_effect(o, ln, c);
        send_item(o, ln, c, any_byte(), any_byte(), any_byte(), any_byte());
    endtask

    // Mostly legal sizes, some clamped ones, noise in the unused data bits
    task automatic random_setting();
        logic [CFG_DATA_W-1:0] cells_v, lines_v;
        case ($urandom_range(3))
            0, 1:    cells_v = CFG_DATA_W'($urandom_range(MIN_CELLS, MAX_CELLS_DEF));
            2:       cells_v = CFG_DATA_W'($urandom_range(MIN_CELLS, 8));
            default: cells_v = CFG_DATA_W'($urandom_range(1) ? $urandom_range(1)
                                                              : $urandom_range(65, 127));
        endcase
        cells_v[7] = 1'($urandom_range(1));
        if ($urandom_range(3) != 0)
            lines_v = CFG_DATA_W'($urandom_range(1, MAX_LINES_DEF));
        else
            lines_v = CFG_DATA_W'($urandom_range(1) ? 0 : $urandom_range(17, 31));
        lines_v[7:5] = 3'($urandom_range(7));
        apply_setting(any_byte(), any_byte(), cells_v, lines_v, $urandom_range(255));
    endtask

    initial
    begin : stimulus
        bit acted;
        int done;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(22, 71);

        // Reset settings: spark at top of range, no spark, cools, saturation
        send_item(OP_FINISH, 0, 0, 0, 0, 255, 255);
        send_item(OP_FINISH, 15, 63, 255, 255, 0, 0);
        send_item(OP_COOL, 15, 63, 255, 0, 0, 0);
        send_item(OP_COOL, 0, 6, 255, 0, 0, 0);
        send_item(OP_COOL, 0, 0, 0, 255, 255, 255);
        send_item(OP_FINISH, 0, 0, 0, 0, 0, 0);
        send_item(OP_FINISH, 0, 0, 0, 0, 0, 255);

        // Shortest line, one line, max cooling, reversed; dropped beats
        apply_setting(255, 255, 2, 1, 0);
        send_item(OP_COOL, 0, 1, 255, 0, 0, 0);
        send_item(OP_COOL, 0, 2, 255, 0, 0, 0);
        send_item(OP_COOL, 1, 0, 255, 0, 0, 0);
        send_item(OP_FINISH, 1, 0, 0, 0, 0, 0);
        send_item(OP_FINISH, 0, 0, 0, 255, 255, 128);
        send_item(OP_FINISH, 0, 0, 0, 0, 0, 0);

        // Zero sizes clamp up, zero cooling and sparking
        apply_setting(0, 0, 0, 0, 1);
        send_item(OP_COOL, 0, 1, 255, 0, 0, 0);
        send_item(OP_FINISH, 0, 0, 0, 0, 255, 255);
        send_item(OP_FINISH, 15, 0, 0, 0, 0, 0);

        // Oversized counts clamp down; heat kept in place across size changes
        apply_setting(200, 200, 255, 255, 0);
        send_item(OP_FINISH, 15, 0, 0, 0, 128, 200);
        send_item(OP_COOL, 15, 63, 255, 0, 0, 0);
        send_item(OP_FINISH, 7, 0, 0, 0, 0, 0);

        // Spark span just below and at the wide span
        apply_setting(100, 255, 6, 4, 1);
        send_item(OP_FINISH, 3, 0, 0, 0, 255, 0);
        apply_setting(100, 255, 7, 4, 1);
        send_item(OP_FINISH, 3, 0, 0, 0, 255, 0);

        // Random phases under changing settings and idling
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 3) set_idle(71, 22);
            if (ph == 6) set_idle(0, 0);
            random_setting();
            if (ph == 6) hold_asks++;
            done = 0;
            while (done < PHASE_ITEMS) begin
                send_random_item(acted);
                if (acted) done++;
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d cool beats, %0d line updates (%0d sparks), %0d dropped beats,",
                 sb.cools, sb.line_updates, sb.sparks, sb.ignored);
        $display("%0d output beats checked over %0d register settings, %0d errors.",
                 sb.beats_checked, settings_used, sb.errors);
        if (sb.errors == 0)
            $display("fire_heat_line_simulator: match");
        else
            $display("fire_heat_line_simulator: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/fhl_pkg.sv
rtl/core/fhl_heat_mem.sv
rtl/core/fhl_div.sv
rtl/core/fhl_cell_pipe.sv
rtl/core/fire_heat_line_simulator.sv
rtl/core/fhl_checker.sv
verif/tb.sv
